// ===== hw/rtl/lzbd_pkg.sv =====
// Shared types and constants for the backward LZ bitstream decoder.
package lzbd_pkg;

  typedef enum logic [2:0] {
    PH_FLAG     = 3'd0,
    PH_LITERAL  = 3'd1,
    PH_DISTANCE = 3'd2,
    PH_LEVEL    = 3'd3,
    PH_EXTRA    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WAIT     = 3'd1,
    ST_DONE     = 3'd2,
    ST_BADREF   = 3'd3,
    ST_UNNEEDED = 3'd4
  } status_e;

  typedef enum logic {
    OP_FEED    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_PARSE = 2'd1,
    BK_READ  = 2'd2,
    BK_EMIT  = 2'd3
  } back_e;

  localparam int unsigned DistBits  = 13;
  localparam int unsigned DistBias  = 3;
  localparam int unsigned ExtraBits = 8;

  // Queued work item from the front part to the back part.
  typedef struct packed {
    logic [0:0] operation;
    logic [7:0] in_byte;
  } work_t;

  // Level field widths for the variable-length copy count.
  function automatic logic [3:0] level_width(input logic [1:0] lvl);
    logic [3:0] w;
    unique case (lvl)
      2'd0: w = 4'd2;
      2'd1: w = 4'd3;
      2'd2: w = 4'd5;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/lzbd_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] operation;
  logic [7:0] in_byte;
  modport source (output valid, output operation, output in_byte, input ready);
  modport sink (input valid, input operation, input in_byte, output ready);
endinterface

interface lzbd_out_if;
  logic       valid;
  logic       ready;
  logic [0:0] out_valid;
  logic [7:0] out_byte;
  logic [2:0] status;
  modport source (output valid, output out_valid, output out_byte, output status,
                  input ready);
  modport sink (input valid, input out_valid, input out_byte, input status,
                output ready);
endinterface

// ===== hw/rtl/lzbd_front.sv =====
// Front part: accepts input items into a two-entry queue.
module lzbd_front
  import lzbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  lzbd_in_if.sink in_ch,
  output work_t wk_o,
  output logic  wk_valid_o,
  input  logic  wk_pop_i
);

  work_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign wk_valid_o  = (cnt_q != 2'd0);
  assign wk_o        = mem_q[rd_q];

  // Advance pointers and the fill count.
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = wk_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, wk_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold queued payloads.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{operation: in_ch.operation, in_byte: in_ch.in_byte};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wk_pop_i |-> cnt_q != 2'd0) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad queue count");

endmodule

// ===== hw/rtl/lzbd_back.sv =====
// Back part: bit parser, copy engine, history window and result register.
module lzbd_back
  import lzbd_pkg::*;
#(
  parameter int unsigned WindowDepth = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] output_length_i,
  input  work_t       wk_i,
  input  logic        wk_valid_i,
  output logic        wk_pop_o,
  lzbd_out_if.source  out_ch
);

  localparam int unsigned AddrBits = $clog2(WindowDepth);
  localparam logic [AddrBits:0] DepthW = (AddrBits + 1)'(WindowDepth);

  back_e       st_q, st_d;
  logic [7:0]  pool_q, pool_d;
  logic [3:0]  brem_q, brem_d;
  phase_e      ph_q, ph_d;
  logic [12:0] acc_q, acc_d;
  logic [3:0]  fbd_q, fbd_d;
  logic [1:0]  lvl_q, lvl_d;
  logic [13:0] dist_q, dist_d;
  logic [31:0] crem_q, crem_d;
  logic [31:0] prod_q, prod_d;
  logic [AddrBits-1:0] wp_q, wp_d;

  logic        ov_q, ov_d;
  logic [0:0]  oval_q, oval_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [2:0]  ost_q, ost_d;

  logic [7:0]  win_q [WindowDepth];
  logic [7:0]  rdata_q;
  logic        we;
  logic [7:0]  wdata;
  logic [AddrBits-1:0] raddr;

  logic        done, pending, slot_free, bit_v;
  logic [12:0] acc_n;
  logic [3:0]  fbd_n, wid;
  logic [31:0] sum;
  logic [32:0] sum_w;
  logic [AddrBits:0]   src_sum;
  logic [AddrBits-1:0] wp_inc;
  logic [31:0] dist_ext;

  assign done      = prod_q >= output_length_i;
  assign pending   = (ph_q == PH_FLAG) && (crem_q != 32'd0);
  assign slot_free = !ov_q || out_ch.ready;
  assign bit_v     = pool_q[brem_q[2:0] - 3'd1];
  assign acc_n     = {acc_q[11:0], bit_v};
  assign fbd_n     = fbd_q + 4'd1;
  assign wid       = (ph_q == PH_LEVEL) ? level_width(lvl_q) : 4'(ExtraBits);
  assign sum_w     = {1'b0, crem_q} + {20'd0, acc_n[11:0]};
  assign sum       = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
  assign dist_ext  = {18'd0, dist_q};
  // Advance the write pointer around the window.
  assign wp_inc    = (wp_q == AddrBits'(WindowDepth - 1)) ? '0 : wp_q + AddrBits'(1);
  // Source slot: write pointer minus distance, modulo window depth.
  assign src_sum   = {1'b0, wp_q} + DepthW - (AddrBits + 1)'(dist_q);
  assign raddr     = (src_sum >= DepthW) ? src_sum[AddrBits-1:0] - DepthW[AddrBits-1:0]
                                         : src_sum[AddrBits-1:0];

  assign out_ch.valid     = ov_q;
  assign out_ch.out_valid = oval_q;
  assign out_ch.out_byte  = obyte_q;
  assign out_ch.status    = ost_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (wk_valid_i && slot_free && wk_i.operation == OP_REQUEST && !done) begin
          st_d = BK_PARSE;
        end
      end
      BK_PARSE: begin
        if (pending) begin
          st_d = BK_READ;
        end else if (brem_q == 4'd0) begin
          st_d = BK_IDLE;
        end else if (ph_q == PH_LITERAL && fbd_n == 4'd8) begin
          st_d = BK_IDLE;
        end
      end
      BK_READ: begin
        st_d = BK_EMIT;
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pool_d = pool_q; brem_d = brem_q; ph_d = ph_q; acc_d = acc_q;
    fbd_d = fbd_q; lvl_d = lvl_q; dist_d = dist_q; crem_d = crem_q;
    prod_d = prod_q; wp_d = wp_q;
    ov_d = ov_q && !out_ch.ready;
    oval_d = oval_q; obyte_d = obyte_q; ost_d = ost_q;
    wk_pop_o = 1'b0; we = 1'b0; wdata = 8'd0;
    unique case (st_q)
      BK_IDLE: begin
        if (wk_valid_i && slot_free) begin
          wk_pop_o = 1'b1;
          if (wk_i.operation == OP_FEED) begin
            ov_d = 1'b1; oval_d = 1'b0; obyte_d = 8'd0;
            if (done || brem_q != 4'd0 || pending) begin
              ost_d = ST_UNNEEDED;
            end else begin
              pool_d = wk_i.in_byte; brem_d = 4'd8; ost_d = ST_OK;
            end
          end else if (done) begin
            ov_d = 1'b1; oval_d = 1'b0; obyte_d = 8'd0; ost_d = ST_DONE;
          end
        end
      end
      BK_PARSE: begin
        // Consume one bit per cycle until a byte or copy is ready or the fed bits run out.
        if (pending) begin
        end else if (brem_q == 4'd0) begin
          ov_d = 1'b1; oval_d = 1'b0; obyte_d = 8'd0; ost_d = ST_WAIT;
        end else begin
          brem_d = brem_q - 4'd1;
          unique case (ph_q)
            PH_FLAG: begin
              ph_d = bit_v ? PH_DISTANCE : PH_LITERAL;
              acc_d = 13'd0; fbd_d = 4'd0;
            end
            PH_LITERAL: begin
              acc_d = acc_n; fbd_d = fbd_n;
              if (fbd_n == 4'd8) begin
                ph_d = PH_FLAG; acc_d = 13'd0; fbd_d = 4'd0;
                we = 1'b1; wdata = acc_n[7:0];
                prod_d = prod_q + 32'd1; wp_d = wp_inc;
                ov_d = 1'b1; oval_d = 1'b1; obyte_d = acc_n[7:0]; ost_d = ST_OK;
              end
            end
            PH_DISTANCE: begin
              acc_d = acc_n; fbd_d = fbd_n;
              if (fbd_n == 4'(DistBits)) begin
                dist_d = {1'b0, acc_n} + 14'(DistBias);
                crem_d = 32'd3; lvl_d = 2'd0; ph_d = PH_LEVEL;
                acc_d = 13'd0; fbd_d = 4'd0;
              end
            end
            default: begin
              acc_d = acc_n; fbd_d = fbd_n;
              if (fbd_n == wid) begin
                acc_d = 13'd0; fbd_d = 4'd0; crem_d = sum;
                if (acc_n[7:0] != 8'((9'd1 << wid) - 9'd1)) begin
                  ph_d = PH_FLAG;
                end else if (ph_q == PH_LEVEL) begin
                  if (lvl_q != 2'd3) lvl_d = lvl_q + 2'd1;
                  else ph_d = PH_EXTRA;
                end
              end
            end
          endcase
        end
      end
      BK_READ: begin
      end
      default: begin
        // Emit one copy byte from the registered window read, or a bad-reference result.
        crem_d = crem_q - 32'd1;
        prod_d = prod_q + 32'd1; wp_d = wp_inc;
        we = 1'b1; ov_d = 1'b1;
        if (prod_q < dist_ext) begin
          wdata = 8'd0; oval_d = 1'b0; obyte_d = 8'd0; ost_d = ST_BADREF;
        end else begin
          wdata = rdata_q; oval_d = 1'b1; obyte_d = rdata_q; ost_d = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; pool_q <= 8'd0; brem_q <= 4'd0; ph_q <= PH_FLAG;
      acc_q <= 13'd0; fbd_q <= 4'd0; lvl_q <= 2'd0; dist_q <= 14'd0;
      crem_q <= 32'd0; prod_q <= 32'd0; wp_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; pool_q <= pool_d; brem_q <= brem_d; ph_q <= ph_d;
      acc_q <= acc_d; fbd_q <= fbd_d; lvl_q <= lvl_d; dist_q <= dist_d;
      crem_q <= crem_d; prod_q <= prod_d; wp_q <= wp_d; ov_q <= ov_d;
    end
  end

  // Hold result payload.
  always_ff @(posedge clk_i) begin
    oval_q <= oval_d; obyte_q <= obyte_d; ost_q <= ost_d;
  end

  // History window: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) win_q[wp_q] <= wdata;
    rdata_q <= win_q[raddr];
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wk_pop_o |-> st_q == BK_IDLE) else $error("pop outside idle");
  a_emit_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_EMIT |-> $past(st_q) == BK_READ) else $error("emit without read");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q != $past(prod_q) |-> $rose(ov_q) || ov_q) else $error("silent count step");

endmodule

// ===== hw/rtl/lz_backward_bitstream_decoder.sv =====
// Top level of the backward LZ bitstream decoder.
// Usage: in_ch carries items; operation 0 feeds a compressed byte (taken
// from the end of the stream backwards), operation 1 asks for the next
// decoded byte. out_ch returns exactly one result per item: out_valid,
// out_byte and status (ok, waiting, finished, bad reference, unneeded feed).
// The output length register is written via cfg_we_i/cfg_wdata_i while
// nothing is in flight.
// Sequence: an item leaves the queue at the earliest the cycle after it is
// accepted. A feed or a finished request presents its result the cycle after
// it leaves the queue. A request then parses one bit per cycle (a literal
// token is 9 bits, up to 8 from one fed byte), adds a further parse step if
// it ends waiting for input, and a check, the history-window read and an emit
// step when a copy header completes. A byte of a copy already under way goes
// through: leave the queue, check, the registered history-window read, emit.
// Flow: items are handled one at a time; the back part takes no new item
// until it is through with the last one. A two-entry input queue decouples
// acceptance from decoding and a result register holds the answer while the
// receiver stalls; decoding pauses until the result is taken.
// Reset clears all parsing state, counts and the configured length; the
// window contents are undefined until written and need no clearing.
module lz_backward_bitstream_decoder
  import lzbd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  lzbd_in_if.sink     in_ch,
  lzbd_out_if.source  out_ch
);

  logic [31:0] olen_q;
  work_t       wk;
  logic        wk_valid, wk_pop;

  // Hold the configured output length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olen_q <= 32'd0;
    end else if (cfg_we_i) begin
      olen_q <= cfg_wdata_i;
    end
  end

  lzbd_front u_front (
    .clk_i, .rst_ni, .in_ch,
    .wk_o(wk), .wk_valid_o(wk_valid), .wk_pop_i(wk_pop)
  );

  lzbd_back #(.WindowDepth(WINDOW_DEPTH)) u_back (
    .clk_i, .rst_ni, .output_length_i(olen_q),
    .wk_i(wk), .wk_valid_i(wk_valid), .wk_pop_o(wk_pop), .out_ch
  );

endmodule
